/* sv/ccdf_pkg.sv */
package ccdf_pkg;

   localparam int FIELD_W   = 16;
   // restoring division steps done between two pipeline registers
   localparam int DIV_STEPS = 4;

   localparam logic ACTION_MAP    = 1'b0;
   localparam logic ACTION_INVERT = 1'b1;

   localparam logic [1:0] CSR_LEVEL_LO = 2'd0;
   localparam logic [1:0] CSR_LEVEL_HI = 2'd1;
   localparam logic [1:0] CSR_FRAC_LO  = 2'd2;
   localparam logic [1:0] CSR_FRAC_HI  = 2'd3;

   typedef struct packed {
      logic                action;
      logic [FIELD_W-1:0]  sample_intensity;
      logic [FIELD_W-1:0]  target_fraction;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0]  mapped_fraction;
      logic [FIELD_W-1:0]  mapped_intensity;
      logic                clamped;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_W-1:0]  level_lo;
      logic [FIELD_W-1:0]  level_hi;
      logic [FIELD_W-1:0]  frac_lo;
      logic [FIELD_W-1:0]  frac_hi;
   } cfg_type;

   // item state carried down the bisection chain
   typedef struct packed {
      logic                action;
      logic                clamped;
      logic                eval;    // evaluate the curve at lo once
      logic [FIELD_W-1:0]  lo;
      logic [FIELD_W-1:0]  hi;
      logic [FIELD_W-1:0]  mid;
      logic [FIELD_W-1:0]  y;
   } tag_type;

endpackage

/* sv/ccdf_curve.sv */
module ccdf_curve #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ccdf_pkg::cfg_type cfg,
   input  logic              valid_i,
   input  logic [15:0]       x_i,
   input  ccdf_pkg::tag_type tag_i,
   output logic              valid_o,
   output logic [15:0]       f_o,
   output ccdf_pkg::tag_type tag_o
);
   import ccdf_pkg::*;

   localparam int QW = FRACTION_BITS + 1;
   localparam int DS = (QW + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NS = DS + 5;
   localparam logic [QW-1:0] ONE       = QW'(1) << FRACTION_BITS;
   localparam logic [QW:0]   THREE_ONE = (QW+1)'(3) << FRACTION_BITS;

   logic    valid_ff [NS];
   tag_type tag_ff   [NS];

   logic [FIELD_W-1:0] span;
   logic [FIELD_W-1:0] m;
   logic [FIELD_W:0]   rem_ff [DS+1];
   logic [QW-1:0]      quo_ff [DS+1];
   logic [FIELD_W:0]   rem_in [DS];
   logic [QW-1:0]      quo_in [DS];
   logic               m0_ff;

   logic [2*QW-1:0]    tt;
   logic [QW-1:0]      t2_ff;
   logic [QW:0]        w_ff;
   logic [2*QW:0]      p;
   logic [QW+1:0]      s_raw;
   logic [QW-1:0]      s_ff;
   logic               rise;
   logic [FIELD_W-1:0] dabs;
   logic [FIELD_W+QW-1:0] dm;
   logic [FIELD_W-1:0] mag_ff;
   logic [FIELD_W-1:0] f_ff;

   assign span = cfg.level_hi - cfg.level_lo;
   assign m    = x_i - cfg.level_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= valid_i;
         for (int i = 1; i < NS; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_i;
      for (int i = 1; i < NS; i++) tag_ff[i] <= tag_ff[i-1];
   end

   // the first bits of (m << F) never reach span, so start at m / 2
   always_ff @(posedge clock) begin
      rem_ff[0] <= (FIELD_W+1)'(m[FIELD_W-1:1]);
      m0_ff     <= m[0];
      quo_ff[0] <= '0;
   end

   for (genvar gi = 0; gi < DS; gi++) begin : g_div
      always_comb begin
         logic [FIELD_W:0] r;
         logic [QW-1:0]    q;
         int               k;
         r = rem_ff[gi];
         q = quo_ff[gi];
         for (int j = 0; j < DIV_STEPS; j++) begin
            k = gi * DIV_STEPS + j;
            if (k < QW) begin
               r = {r[FIELD_W-1:0], (k == 0) ? m0_ff : 1'b0};
               if (r >= {1'b0, span}) begin
                  r = r - {1'b0, span};
                  q = {q[QW-2:0], 1'b1};
               end else begin
                  q = {q[QW-2:0], 1'b0};
               end
            end
         end
         rem_in[gi] = r;
         quo_in[gi] = q;
      end

      always_ff @(posedge clock) begin
         rem_ff[gi+1] <= rem_in[gi];
         quo_ff[gi+1] <= quo_in[gi];
      end
   end

   assign tt = quo_ff[DS] * quo_ff[DS];

   always_ff @(posedge clock) begin
      t2_ff <= tt[FRACTION_BITS +: QW];
      w_ff  <= THREE_ONE - {quo_ff[DS], 1'b0};
   end

   assign p     = t2_ff * w_ff;
   assign s_raw = p[FRACTION_BITS +: QW+2];

   always_ff @(posedge clock) begin
      s_ff <= (s_raw > (QW+2)'(ONE)) ? ONE : s_raw[QW-1:0];
   end

   assign rise = cfg.frac_hi >= cfg.frac_lo;
   assign dabs = rise ? (cfg.frac_hi - cfg.frac_lo)
                      : (cfg.frac_lo - cfg.frac_hi);
   assign dm   = dabs * s_ff;

   always_ff @(posedge clock) begin
      mag_ff <= dm[FRACTION_BITS +: FIELD_W];
   end

   always_ff @(posedge clock) begin
      f_ff <= rise ? (cfg.frac_lo + mag_ff) : (cfg.frac_lo - mag_ff);
   end

   assign valid_o = valid_ff[NS-1];
   assign tag_o   = tag_ff[NS-1];
   assign f_o     = f_ff;

endmodule

/* sv/ccdf_step.sv */
module ccdf_step #(
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  ccdf_pkg::cfg_type cfg,
   input  logic              valid_i,
   input  ccdf_pkg::tag_type tag_i,
   output logic              valid_o,
   output ccdf_pkg::tag_type tag_o
);
   import ccdf_pkg::*;

   logic [FIELD_W:0]   gap;
   logic [FIELD_W-1:0] mid;
   logic [FIELD_W-1:0] x;
   tag_type            ctag_in;
   logic               cvalid;
   logic [FIELD_W-1:0] cf;
   tag_type            ctag;
   tag_type            tag_in;
   logic               valid_ff;
   tag_type            tag_ff;

   assign gap = {1'b0, tag_i.hi} - {1'b0, tag_i.lo} + (FIELD_W+1)'(1);
   assign mid = tag_i.lo + gap[FIELD_W:1];
   assign x   = tag_i.eval ? tag_i.lo : mid;

   always_comb begin
      ctag_in     = tag_i;
      ctag_in.mid = mid;
   end

   ccdf_curve #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_curve (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .valid_i (valid_i),
      .x_i     (x),
      .tag_i   (ctag_in),
      .valid_o (cvalid),
      .f_o     (cf),
      .tag_o   (ctag)
   );

   always_comb begin
      tag_in = ctag;
      if (ctag.eval) begin
         tag_in.lo   = cf;
         tag_in.hi   = cf;
         tag_in.eval = 1'b0;
      end else if (ctag.lo < ctag.hi) begin
         if (cf <= ctag.y) begin
            tag_in.lo = ctag.mid;
         end else begin
            tag_in.hi = ctag.mid - 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cvalid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign valid_o = valid_ff;
   assign tag_o   = tag_ff;

endmodule

/* sv/cubic_cdf_map_and_inverse.sv */
// zero-slope cubic map between intensity and cumulative fraction, and its
// inverse. fully pipelined: one item may start in every cycle, busy stays low,
// and each item gives one result on rsp_payload with rsp_valid high for one
// cycle, in the order taken. results pass through the chain of bisection
// steps, each holding its own pipelined curve evaluator with a
// four-bit-per-stage divider. the receiver cannot stall, so results are
// never held back. write the csr registers only while no item is in flight.
module cubic_cdf_map_and_inverse #(
   parameter int INTENSITY_BITS = 16,
   parameter int FRACTION_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ccdf_pkg::req_type req_payload,
   output logic              rsp_valid,
   output ccdf_pkg::rsp_type rsp_payload,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data
);
   import ccdf_pkg::*;

   cfg_type cfg_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_lo <= 16'd0;
         cfg_ff.level_hi <= 16'hFFFF;
         cfg_ff.frac_lo  <= 16'd0;
         cfg_ff.frac_hi  <= 16'hFFFF;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LEVEL_LO: cfg_ff.level_lo <= csr_write_data;
            CSR_LEVEL_HI: cfg_ff.level_hi <= csr_write_data;
            CSR_FRAC_LO:  cfg_ff.frac_lo  <= csr_write_data;
            CSR_FRAC_HI:  cfg_ff.frac_hi  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // the pipeline never stalls
   assign busy = 1'b0;

   logic    degenerate;
   tag_type tag_in;
   logic    valid_ff;
   tag_type tag_ff;

   assign degenerate = cfg_ff.level_hi <= cfg_ff.level_lo;

   // sort the item: finished items get lo == hi so no step touches them
   always_comb begin
      tag_in.action  = req_payload.action;
      tag_in.clamped = 1'b0;
      tag_in.eval    = 1'b0;
      tag_in.lo      = cfg_ff.level_lo;
      tag_in.hi      = cfg_ff.level_lo;
      tag_in.mid     = '0;
      tag_in.y       = req_payload.target_fraction;
      if (req_payload.action == ACTION_MAP) begin
         if (degenerate) begin
            tag_in.lo = cfg_ff.frac_lo;
            tag_in.hi = cfg_ff.frac_lo;
         end else begin
            // evaluate once in the first step, at the clamped intensity
            tag_in.eval = 1'b1;
            if (req_payload.sample_intensity < cfg_ff.level_lo) begin
               tag_in.clamped = 1'b1;
               tag_in.lo      = cfg_ff.level_lo;
            end else if (req_payload.sample_intensity > cfg_ff.level_hi) begin
               tag_in.clamped = 1'b1;
               tag_in.lo      = cfg_ff.level_hi;
            end else begin
               tag_in.lo = req_payload.sample_intensity;
            end
            tag_in.hi = tag_in.lo;
         end
      end else begin
         if (degenerate || cfg_ff.frac_hi < cfg_ff.frac_lo) begin
            // falling or empty region: answer is the lower end
         end else if (req_payload.target_fraction < cfg_ff.frac_lo) begin
            tag_in.clamped = 1'b1;
         end else if (req_payload.target_fraction > cfg_ff.frac_hi) begin
            tag_in.clamped = 1'b1;
            tag_in.lo      = cfg_ff.level_hi;
            tag_in.hi      = cfg_ff.level_hi;
         end else begin
            // full bisection over the region
            tag_in.hi = cfg_ff.level_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   // chain of bisection steps, each with its own curve evaluator
   logic    step_valid [INTENSITY_BITS+1];
   tag_type step_tag   [INTENSITY_BITS+1];

   assign step_valid[0] = valid_ff;
   assign step_tag[0]   = tag_ff;

   for (genvar gi = 0; gi < INTENSITY_BITS; gi++) begin : g_step
      ccdf_step #(
         .FRACTION_BITS (FRACTION_BITS)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .valid_i (step_valid[gi]),
         .tag_i   (step_tag[gi]),
         .valid_o (step_valid[gi+1]),
         .tag_o   (step_tag[gi+1])
      );
   end

   // result register: lo holds the fraction for a map, the intensity otherwise
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   tag_type last;

   assign last = step_tag[INTENSITY_BITS];

   always_comb begin
      rsp_in.mapped_fraction  = (last.action == ACTION_MAP)    ? last.lo : '0;
      rsp_in.mapped_intensity = (last.action == ACTION_INVERT) ? last.lo : '0;
      rsp_in.clamped          = last.clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= step_valid[INTENSITY_BITS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // one transfer per strobe
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import ccdf_pkg::*;

   localparam int LATENCY    = 178;
   localparam int STEPS      = 16;
   localparam int FBITS      = 16;
   localparam int CYCLE_CAP  = 400000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_valid;
   rsp_type           rsp_payload;
   logic              csr_write_en;
   logic [1:0]        csr_index;
   logic [15:0]       csr_write_data;

   // region registers as the block should hold them
   cfg_type           region;
   req_type           pending_items[$];
   rsp_type           expected_maps[$];
   int                gap_left;
   bit                calm;        // no idling in the closing stretch
   bit                failed;
   int                cycles;

   cubic_cdf_map_and_inverse DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // curve value at x, x inside a non-degenerate region
   function automatic logic [15:0] curve_value(logic [15:0] x);
      longint unsigned one, span, t, t2, s, mag;
      one  = 64'd1 << FBITS;
      span = region.level_hi - region.level_lo;
      t    = (longint'(x - region.level_lo) << FBITS) / span;
      t2   = (t * t) >> FBITS;
      s    = (t2 * (3 * one - 2 * t)) >> FBITS;
      if (s > one) begin
         s = one;
      end
      if (region.frac_hi >= region.frac_lo) begin
         mag = ((region.frac_hi - region.frac_lo) * s) >> FBITS;
         return region.frac_lo + mag[15:0];
      end
      mag = ((region.frac_lo - region.frac_hi) * s) >> FBITS;
      return region.frac_lo - mag[15:0];
   endfunction

   function automatic rsp_type map_item(req_type item);
      rsp_type     r;
      logic [16:0] lo, hi, mid;
      bit          flat;
      r    = '0;
      flat = region.level_hi <= region.level_lo;
      if (item.action == ACTION_MAP) begin
         if (flat) begin
            r.mapped_fraction = region.frac_lo;
         end else if (item.sample_intensity < region.level_lo) begin
            r.mapped_fraction = curve_value(region.level_lo);
            r.clamped = 1'b1;
         end else if (item.sample_intensity > region.level_hi) begin
            r.mapped_fraction = curve_value(region.level_hi);
            r.clamped = 1'b1;
         end else begin
            r.mapped_fraction = curve_value(item.sample_intensity);
         end
      end else begin
         if (flat || region.frac_hi < region.frac_lo) begin
            r.mapped_intensity = region.level_lo;
         end else if (item.target_fraction < region.frac_lo) begin
            r.mapped_intensity = region.level_lo;
            r.clamped = 1'b1;
         end else if (item.target_fraction > region.frac_hi) begin
            r.mapped_intensity = region.level_hi;
            r.clamped = 1'b1;
         end else begin
            // bisection for the largest intensity not above the target
            lo = {1'b0, region.level_lo};
            hi = {1'b0, region.level_hi};
            for (int k = 0; k < STEPS; k++) begin
               if (lo < hi) begin
                  mid = lo + ((hi - lo + 17'd1) >> 1);
                  if (curve_value(mid[15:0]) <= item.target_fraction) begin
                     lo = mid;
                  end else begin
                     hi = mid - 17'd1;
                  end
               end
            end
            r.mapped_intensity = lo[15:0];
         end
      end
      return r;
   endfunction

   // driver: one transfer per accepted start, random gaps between them
   always @(posedge clock) begin
      req_type next_item;
      logic    next_start;
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         next_start = start;
         next_item  = req_payload;
         if (start && !busy) begin
            expected_maps.push_back(map_item(req_payload));
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
               if (!calm && $urandom_range(0, 7) == 0) begin
                  gap_left <= int'($urandom_range(1, 13)) - 1;
               end else begin
                  next_item  = pending_items.pop_front();
                  next_start = 1'b1;
               end
            end
         end
         start       <= next_start;
         req_payload <= next_item;
      end
   end

   // monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_maps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            failed = 1'b1;
         end else begin
            want = expected_maps.pop_front();
            if (rsp_payload.mapped_fraction !== want.mapped_fraction) begin
               $display("%0t: mapped_fraction expected %h actual %h", $time,
                        want.mapped_fraction, rsp_payload.mapped_fraction);
               failed = 1'b1;
            end
            if (rsp_payload.mapped_intensity !== want.mapped_intensity) begin
               $display("%0t: mapped_intensity expected %h actual %h", $time,
                        want.mapped_intensity, rsp_payload.mapped_intensity);
               failed = 1'b1;
            end
            if (rsp_payload.clamped !== want.clamped) begin
               $display("%0t: clamped expected %b actual %b", $time,
                        want.clamped, rsp_payload.clamped);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_LEVEL_LO: region.level_lo = value;
         CSR_LEVEL_HI: region.level_hi = value;
         CSR_FRAC_LO:  region.frac_lo  = value;
         default:      region.frac_hi  = value;
      endcase
   endtask

   task automatic set_region(logic [15:0] imin, logic [15:0] imax,
                             logic [15:0] pmin, logic [15:0] pmax);
      write_reg(CSR_LEVEL_LO, imin);
      write_reg(CSR_LEVEL_HI, imax);
      write_reg(CSR_FRAC_LO, pmin);
      write_reg(CSR_FRAC_HI, pmax);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic add_item(logic act, logic [15:0] x, logic [15:0] y);
      req_type item;
      item.action           = act;
      item.sample_intensity = x;
      item.target_fraction  = y;
      pending_items.push_back(item);
   endtask

   // mostly in-region values with random content, some over the full range
   task automatic add_random(int count);
      logic [15:0] x, y;
      for (int k = 0; k < count; k++) begin
         x = 16'($urandom_range(0, 65535));
         y = 16'($urandom_range(0, 65535));
         if ($urandom_range(0, 3) != 0 && region.level_hi > region.level_lo)
            x = 16'($urandom_range(region.level_lo, region.level_hi));
         if ($urandom_range(0, 3) != 0 && region.frac_hi >= region.frac_lo)
            y = 16'($urandom_range(region.frac_lo, region.frac_hi));
         add_item(1'($urandom_range(0, 1)), x, y);
      end
   endtask

   // wait until the pipe has drained, so registers may change
   task automatic drain();
      while (pending_items.size() != 0 || start || expected_maps.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_LEVEL_LO;
      csr_write_data = '0;
      failed         = 1'b0;
      calm           = 1'b0;
      cycles         = 0;
      region         = '{16'd0, 16'd65535, 16'd0, 16'd65535};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and both actions at the reset region
      add_item(ACTION_MAP, 16'd0, 16'd0);
      add_item(ACTION_MAP, 16'hFFFF, 16'hFFFF);
      add_item(ACTION_MAP, 16'h8000, 16'h0000);
      add_item(ACTION_MAP, 16'h5555, 16'hAAAA);
      add_item(ACTION_INVERT, 16'd0, 16'd0);
      add_item(ACTION_INVERT, 16'hFFFF, 16'hFFFF);
      add_item(ACTION_INVERT, 16'hAAAA, 16'h5555);
      add_item(ACTION_INVERT, 16'h0000, 16'h8000);
      drain();

      // interior region: clamping below and above on both actions
      set_region(16'd1000, 16'd60000, 16'd2000, 16'd50000);
      add_item(ACTION_MAP, 16'd0, 16'd0);
      add_item(ACTION_MAP, 16'hFFFF, 16'd0);
      add_item(ACTION_MAP, 16'd1000, 16'd0);
      add_item(ACTION_MAP, 16'd60000, 16'd0);
      add_item(ACTION_INVERT, 16'd0, 16'd0);
      add_item(ACTION_INVERT, 16'd0, 16'hFFFF);
      add_item(ACTION_INVERT, 16'd0, 16'd2000);
      add_item(ACTION_INVERT, 16'd0, 16'd50000);
      add_random(80);
      drain();

      // degenerate region, equal ends then reversed ends
      set_region(16'd300, 16'd300, 16'd700, 16'd900);
      add_item(ACTION_MAP, 16'd300, 16'd0);
      add_item(ACTION_INVERT, 16'd0, 16'd800);
      add_random(40);
      drain();
      set_region(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      add_random(40);
      drain();

      // falling curve
      set_region(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      add_random(80);
      drain();

      // flat fraction and a tiny region
      set_region(16'd100, 16'd110, 16'd4000, 16'd4000);
      add_random(60);
      drain();
      set_region(16'd5, 16'd6, 16'd0, 16'hFFFF);
      add_random(60);
      drain();

      // random regions
      for (int p = 0; p < 4; p++) begin
         set_region(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 32767)), 16'($urandom_range(32768, 65535)));
         add_random(70);
         drain();
      end

      // closing stretch without idling, back at full range
      set_region(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      calm = 1'b1;
      add_random(80);
      drain();

      if (!failed) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
